// ===== sv/skf_pkg.sv =====
// shared types and constants for the scalar range kalman filter
// no dependencies; imported by skf_regs, skf_div and the top level
package skf_pkg;

  localparam int MEAS_W      = 16;
  localparam int EST_W       = 24;
  localparam int COV_W       = 32;
  localparam int NOISE_W     = 16;
  localparam int GAIN_OUT_W  = 16;
  localparam int NOISE_SHIFT = 8;
  localparam int RESET_MM    = 100;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [NOISE_W-1:0] PNOISE_RESET = 16'd512;
  localparam logic [NOISE_W-1:0] MNOISE_RESET = 16'd1024;

  // register select bit of paddr
  localparam logic REG_PNOISE = 1'b0;
  localparam logic REG_MNOISE = 1'b1;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_SEED = 1'b1;

  typedef struct packed {
    logic              op;
    logic [MEAS_W-1:0] measurement;
  } skf_in_t;

  typedef struct packed {
    logic [EST_W-1:0]      estimate;
    logic [GAIN_OUT_W-1:0] gain;
  } skf_out_t;

  typedef struct packed {
    logic [NOISE_W-1:0] process_noise;
    logic [NOISE_W-1:0] measure_noise;
  } skf_cfg_t;

endpackage

// ===== sv/skf_regs.sv =====
// apb register file holding the process and measurement noise settings
// depends on skf_pkg
module skf_regs
  import skf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output skf_cfg_t          cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // byte lane bits paddr[1:0] do not take part in the decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.process_noise <= PNOISE_RESET;
      cfg.measure_noise <= MNOISE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_PNOISE: cfg.process_noise <= pwdata[NOISE_W-1:0];
        REG_MNOISE: cfg.measure_noise <= pwdata[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PNOISE: prdata = APB_DW'(cfg.process_noise);
      REG_MNOISE: prdata = APB_DW'(cfg.measure_noise);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== sv/skf_div.sv =====
// restoring divider, one quotient bit per cycle, for the kalman gain
// expects num < den; depends on skf_pkg
module skf_div
  import skf_pkg::*;
#(
  parameter int GAIN_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [COV_W-1:0]     num,
  input  logic [COV_W:0]       den,
  output logic                 done,
  output logic [GAIN_BITS-1:0] quot
);

  localparam int CNT_W = $clog2(GAIN_BITS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [COV_W:0]   rem;
  logic [COV_W:0]   dvs;
  logic [COV_W+1:0] shifted;
  logic [COV_W+1:0] diff;
  logic             ge;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(GAIN_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      dvs  <= den;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[COV_W:0] : shifted[COV_W:0];
      quot <= {quot[GAIN_BITS-2:0], ge};
    end
  end

endmodule

// ===== sv/scalar_kalman_range_filter.sv =====
// channel  | dir | handshake                | payload
// meas     | in  | meas_valid / meas_stall   | skf_in_t  (op, measurement)
// result   | out | result_valid / result_stall | skf_out_t (estimate, gain)
// cfg      | in  | apb psel / penable / pready | process_noise, measure_noise
//
// acceptance to next acceptance: a seed goes through ST_DONE only, a filter step through
// ST_PRED, ST_DEN, the bit-serial gain divider (ST_DIV) and the shared multiplier used
// twice (ST_MUL_EST, ST_MUL_COV), then ST_DONE; the result is valid once meas_stall falls
// with zero measurement noise the divider is skipped and ST_DEN goes straight to the multiplier
// meas_stall is high from acceptance until the result is loaded into the output register
// a full output register held by result_stall delays that load and the next acceptance
// synchronous active-high rst sets estimate to 100 mm, covariance to zero, noises to defaults
// depends on skf_pkg, skf_regs, skf_div
module scalar_kalman_range_filter
  import skf_pkg::*;
#(
  parameter int EST_FRAC_BITS = 8,
  parameter int GAIN_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              meas_valid,
  output logic              meas_stall,
  input  skf_in_t           meas,
  output logic              result_valid,
  input  logic              result_stall,
  output skf_out_t          result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int ONE_W  = GAIN_BITS + 1;
  localparam int PROD_W = ONE_W + COV_W;
  localparam logic [EST_W-1:0] EST_RESET = EST_W'(RESET_MM << EST_FRAC_BITS);
  localparam logic [ONE_W-1:0] GAIN_ONE  = ONE_W'(1) << GAIN_BITS;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_PRED    = 7'b0000010,
    ST_DEN     = 7'b0000100,
    ST_DIV     = 7'b0001000,
    ST_MUL_EST = 7'b0010000,
    ST_MUL_COV = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  function automatic logic [EST_W-1:0] meas_to_est(input logic [MEAS_W-1:0] m);
    logic [31:0] w;
    w = 32'(m) << EST_FRAC_BITS;
    return (|w[31:EST_W]) ? {EST_W{1'b1}} : w[EST_W-1:0];
  endfunction

  state_t               state;
  skf_cfg_t             cfg;
  logic [EST_W-1:0]     estimate_reg;
  logic [COV_W-1:0]     covariance_reg;
  logic                 is_seed;
  logic [EST_W-1:0]     z;
  logic [EST_W-1:0]     mag;
  logic                 up;
  logic [COV_W-1:0]     pmid;
  logic [GAIN_BITS-1:0] g;
  logic [PROD_W-1:0]    prod;
  logic [EST_W-1:0]     res_est;
  logic [GAIN_OUT_W-1:0] res_gain;
  logic [COV_W:0]       pred_sum;
  logic [COV_W:0]       den;
  logic                 div_start;
  logic                 div_done;
  logic [GAIN_BITS-1:0] div_quot;
  logic [ONE_W-1:0]     mul_a;
  logic [COV_W-1:0]     mul_b;
  logic [EST_W-1:0]     corr;
  logic [31:0]          g_wide;
  logic                 meas_acc;
  logic                 out_free;

  skf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  skf_div #(
    .GAIN_BITS (GAIN_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (pmid),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign meas_stall = (state != ST_IDLE);
  assign meas_acc   = meas_valid && !meas_stall;
  assign out_free   = !result_valid || !result_stall;

  assign pred_sum  = {1'b0, covariance_reg} + ((COV_W+1)'(cfg.process_noise) << NOISE_SHIFT);
  assign den       = {1'b0, pmid} + ((COV_W+1)'(cfg.measure_noise) << NOISE_SHIFT);
  // with zero measurement noise the gain is handled without the divider
  assign div_start = (state == ST_DEN) && (cfg.measure_noise != '0);

  // shared multiplier: correction first, then covariance shrink
  always_comb begin
    if (state == ST_MUL_EST) begin
      mul_a = ONE_W'(g);
      mul_b = COV_W'(mag);
    end else begin
      mul_a = GAIN_ONE - ONE_W'(g);
      mul_b = pmid;
    end
  end

  assign corr   = prod[GAIN_BITS +: EST_W];
  assign g_wide = 32'(g);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      result_valid   <= 1'b0;
      estimate_reg   <= EST_RESET;
      covariance_reg <= '0;
    end else begin
      // a commit in the same cycle reloads the output register instead
      if (result_valid && !result_stall && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (meas_acc) begin
            state <= (meas.op == OP_SEED) ? ST_DONE : ST_PRED;
          end
        end
        ST_PRED:    state <= ST_DEN;
        ST_DEN:     state <= div_start ? ST_DIV : ST_MUL_EST;
        ST_DIV: begin
          if (div_done) begin
            state <= ST_MUL_EST;
          end
        end
        ST_MUL_EST: state <= ST_MUL_COV;
        ST_MUL_COV: state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            estimate_reg <= res_est;
            if (!is_seed) begin
              covariance_reg <= prod[GAIN_BITS +: COV_W];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (meas_acc) begin
          is_seed  <= (meas.op == OP_SEED);
          z        <= meas_to_est(meas.measurement);
          res_est  <= meas_to_est(meas.measurement);
          res_gain <= '0;
        end
      end
      ST_PRED: begin
        pmid <= pred_sum[COV_W] ? {COV_W{1'b1}} : pred_sum[COV_W-1:0];
        up   <= (z >= estimate_reg);
        mag  <= (z >= estimate_reg) ? z - estimate_reg : estimate_reg - z;
      end
      ST_DEN: begin
        if (!div_start) begin
          g <= (pmid != '0) ? {GAIN_BITS{1'b1}} : '0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          g <= div_quot;
        end
      end
      ST_MUL_EST: begin
        prod <= mul_a * PROD_W'(mul_b);
      end
      ST_MUL_COV: begin
        res_est  <= up ? estimate_reg + corr : estimate_reg - corr;
        res_gain <= (|g_wide[31:GAIN_OUT_W]) ? {GAIN_OUT_W{1'b1}} : g_wide[GAIN_OUT_W-1:0];
        prod     <= mul_a * PROD_W'(mul_b);
      end
      ST_DONE: begin
        if (out_free) begin
          result.estimate <= res_est;
          result.gain     <= res_gain;
        end
      end
      default: ;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    meas_acc |=> state != ST_IDLE)
    else $error("accepted transaction did not start the sequencer");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_cov_only_in_done: assert property (@(posedge clk) disable iff (rst)
    state != ST_DONE |=> $stable(covariance_reg))
    else $error("covariance changed outside the commit phase");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result raised without a commit");

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for scalar_kalman_range_filter: directed table, then random phases
// a behavioral kalman predictor checks untyped items; needs skf_pkg and the filter rtl
`timescale 1ns / 1ps

module testbench;
  import skf_pkg::*;

  localparam int FRAC_W          = 8;
  localparam int GAIN_FRAC       = 16;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int TAIL_CYCLES     = 48;

  localparam logic [63:0] EST_CEIL      = (64'd1 << EST_W) - 1;
  localparam logic [63:0] COV_CEIL      = (64'd1 << COV_W) - 1;
  localparam logic [63:0] GAIN_OUT_CEIL = (64'd1 << GAIN_OUT_W) - 1;

  typedef struct {
    logic               is_write;
    logic               reg_sel;
    logic [NOISE_W-1:0] wval;
    skf_in_t            item;
    logic               typed;
    skf_out_t           want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              meas_valid = 1'b0;
  logic              meas_stall;
  skf_in_t           meas = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  skf_out_t          result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // predictor state and register copies
  logic [EST_W-1:0]   est_track = EST_W'(RESET_MM << FRAC_W);
  logic [COV_W-1:0]   cov_track = '0;
  logic [NOISE_W-1:0] q_track = PNOISE_RESET;
  logic [NOISE_W-1:0] r_track = MNOISE_RESET;

  skf_out_t    pending_estimates[$];
  dir_row_t    dir_table[$];
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int          mismatches = 0;
  int          n_items = 0;
  int          n_checked = 0;
  int          n_writes = 0;
  int          quiet_cycles = 0;

  scalar_kalman_range_filter #(
    .EST_FRAC_BITS(FRAC_W),
    .GAIN_BITS(GAIN_FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .meas_valid(meas_valid),
    .meas_stall(meas_stall),
    .meas(meas),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic skf_out_t kalman_update(input skf_in_t it);
    logic [63:0] unity, pmid, den, g, x, z, corr, newx, pnew;
    skf_out_t res;
    unity = 64'd1 << GAIN_FRAC;
    z = 64'(it.measurement) << FRAC_W;
    if (z > EST_CEIL) z = EST_CEIL;
    if (it.op == OP_SEED) begin
      est_track = z[EST_W-1:0];
      res.estimate = est_track;
      res.gain = '0;
      return res;
    end
    pmid = 64'(cov_track) + (64'(q_track) << NOISE_SHIFT);
    if (pmid > COV_CEIL) pmid = COV_CEIL;
    den = pmid + (64'(r_track) << NOISE_SHIFT);
    if (den == 64'd0) begin
      g = 64'd0;
    end else begin
      g = (pmid << GAIN_FRAC) / den;
      if (g > unity - 1) g = unity - 1;
    end
    x = 64'(est_track);
    if (z >= x) begin
      newx = x + (((z - x) * g) >> GAIN_FRAC);
    end else begin
      // magnitude is truncated first, then pulls the estimate down
      corr = ((x - z) * g) >> GAIN_FRAC;
      newx = (corr > x) ? 64'd0 : x - corr;
    end
    if (newx > EST_CEIL) newx = EST_CEIL;
    est_track = newx[EST_W-1:0];
    pnew = ((unity - g) * pmid) >> GAIN_FRAC;
    cov_track = (pnew > COV_CEIL) ? COV_CEIL[COV_W-1:0] : pnew[COV_W-1:0];
    res.estimate = est_track;
    res.gain = (g > GAIN_OUT_CEIL) ? GAIN_OUT_CEIL[GAIN_OUT_W-1:0] : g[GAIN_OUT_W-1:0];
    return res;
  endfunction

  function automatic void cfg_row(input logic sel, input logic [NOISE_W-1:0] val);
    dir_row_t r;
    r.is_write = 1'b1;
    r.reg_sel = sel;
    r.wval = val;
    r.item = '0;
    r.typed = 1'b0;
    r.want = '0;
    dir_table.push_back(r);
  endfunction

  function automatic void item_row(input logic op, input logic [MEAS_W-1:0] m,
                                   input logic typed, input logic [EST_W-1:0] est,
                                   input logic [GAIN_OUT_W-1:0] gain);
    dir_row_t r;
    r.is_write = 1'b0;
    r.reg_sel = REG_PNOISE;
    r.wval = '0;
    r.item.op = op;
    r.item.measurement = m;
    r.typed = typed;
    r.want.estimate = est;
    r.want.gain = gain;
    dir_table.push_back(r);
  endfunction

  function automatic int clamp_mm(input int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input skf_in_t it, input logic typed, input skf_out_t known);
    skf_out_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      meas_valid <= 1'b0;
      @(negedge clk);
    end
    meas_valid <= 1'b1;
    meas <= it;
    do @(posedge clk); while (meas_stall);
    pred = kalman_update(it);
    pending_estimates.push_back(typed ? known : pred);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    meas_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // setup cycle, then access cycle; pready is tied high
  task automatic write_noise(input logic sel, input logic [NOISE_W-1:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {sel, 2'b00};
    pwdata <= {{(APB_DW-NOISE_W){1'b0}}, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_PNOISE) q_track = val;
    else r_track = val;
    n_writes++;
  endtask

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    skf_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_estimates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: estimate=%0d gain=%0d", result.estimate, result.gain);
      end else begin
        want = pending_estimates.pop_front();
        n_checked++;
        if (result.estimate !== want.estimate || result.gain !== want.gain) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: estimate exp %0d got %0d, gain exp %0d got %0d",
                     $realtime, want.estimate, result.estimate, want.gain, result.gain);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((meas_valid && !meas_stall) || (result_valid && !result_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned src_mode[4];
    int unsigned sink_mode[4];
    logic [NOISE_W-1:0] qv, rv;
    skf_in_t it;
    int walk, m, roll;

    src_mode = '{0, 45, 0, 29};
    sink_mode = '{0, 0, 45, 29};
    walk = 1500;

    // zero denominator straight out of reset: covariance is still zero
    cfg_row(REG_PNOISE, 16'd0);
    cfg_row(REG_MNOISE, 16'd0);
    item_row(OP_STEP, 16'd500, 1'b1, 24'd25600, 16'd0);
    item_row(OP_SEED, 16'd0, 1'b1, 24'd0, 16'd0);
    // no measurement noise: gain saturates
    cfg_row(REG_PNOISE, 16'hFFFF);
    item_row(OP_STEP, 16'hFFFF, 1'b0, '0, '0);
    item_row(OP_STEP, 16'd0, 1'b0, '0, '0);
    item_row(OP_STEP, 16'd0, 1'b0, '0, '0);
    // covariance collapses to zero, denominator drops out again
    cfg_row(REG_PNOISE, 16'd0);
    item_row(OP_STEP, 16'd777, 1'b0, '0, '0);
    item_row(OP_STEP, 16'd777, 1'b0, '0, '0);
    item_row(OP_STEP, 16'd777, 1'b0, '0, '0);
    cfg_row(REG_PNOISE, PNOISE_RESET);
    cfg_row(REG_MNOISE, MNOISE_RESET);
    item_row(OP_SEED, 16'hFFFF, 1'b1, 24'd16776960, 16'd0);
    item_row(OP_STEP, 16'd0, 1'b0, '0, '0);
    item_row(OP_STEP, 16'hFFFF, 1'b0, '0, '0);
    item_row(OP_STEP, 16'd1, 1'b0, '0, '0);
    item_row(OP_STEP, 16'h5555, 1'b0, '0, '0);
    item_row(OP_STEP, 16'hAAAA, 1'b0, '0, '0);
    cfg_row(REG_PNOISE, 16'hFFFF);
    cfg_row(REG_MNOISE, 16'hFFFF);
    item_row(OP_STEP, 16'd40000, 1'b0, '0, '0);
    item_row(OP_STEP, 16'd40010, 1'b0, '0, '0);
    item_row(OP_STEP, 16'd200, 1'b0, '0, '0);
    cfg_row(REG_PNOISE, 16'd1);
    cfg_row(REG_MNOISE, 16'd1);
    item_row(OP_STEP, 16'd12345, 1'b0, '0, '0);
    item_row(OP_STEP, 16'd12340, 1'b0, '0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].is_write) begin
        wait_idle();
        write_noise(dir_table[i].reg_sel, dir_table[i].wval);
      end else begin
        send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin qv = PNOISE_RESET; rv = MNOISE_RESET; end
        1: begin qv = 16'd0;        rv = 16'd1;        end
        2: begin qv = 16'hFFFF;     rv = 16'hFFFF;     end
        3: begin qv = 16'hFFFF;     rv = 16'd1;        end
        4: begin qv = 16'd0;        rv = 16'hFFFF;     end
        default: begin
          qv = NOISE_W'($urandom_range(65535));
          rv = NOISE_W'($urandom_range(65535, 1));
        end
      endcase
      write_noise(REG_PNOISE, qv);
      write_noise(REG_MNOISE, rv);
      src_idle_pct = src_mode[p % 4];
      sink_stall_pct = sink_mode[p % 4];

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // target drifts slowly, now and then jumps to a new range
        if ($urandom_range(49) == 0) walk = $urandom_range(65535);
        else walk = clamp_mm(walk + int'($urandom_range(20)) - 10);
        roll = $urandom_range(99);
        it.op = OP_STEP;
        if (roll < 12) begin
          it.op = OP_SEED;
          m = walk;
        end else if (roll < 72) begin
          m = clamp_mm(walk + int'($urandom_range(80)) - 40);
        end else if (roll < 80) begin
          m = ($urandom_range(1) == 1) ? 65535 : 0;
        end else begin
          m = $urandom_range(65535);
        end
        it.measurement = m[MEAS_W-1:0];
        send_item(it, 1'b0, '0);
      end
    end

    src_idle_pct = 0;
    sink_stall_pct = 0;
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d transactions in, %0d results checked, %0d mismatches", n_items, n_checked,
             mismatches);
    $display("%0d noise register writes over %0d random phases with mixed idle and stall",
             n_writes, N_PHASES);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
